@@ hw/rtl/dhb_pkg.sv @@
// Package for the dual H-bridge ramp controller.
// Holds direction, action, status and register index codes and the request and
// result payload structs. No dependencies.
package dhb_pkg;

	// PWM period; clamps for target duty and for the deadband floor
	localparam logic [15:0] PWM_PERIOD = 16'd1000;

	// Default width of the reversal hold counter
	localparam int HOLD_BITS_DEF = 8;

	// Level and register widths fixed by the payload
	localparam int LEVEL_W = 10;
	localparam int TICKS_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [1:0] {
		DIR_COAST = 2'd0,
		DIR_FWD   = 2'd1,
		DIR_REV   = 2'd2,
		DIR_BRAKE = 2'd3
	} dir_t;

	typedef enum logic {
		ACT_CMD  = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic {
		ST_OK     = 1'b0,
		ST_BAD_ID = 1'b1
	} status_t;

	localparam logic [1:0] MOTOR_LEFT = 2'd0;
	localparam logic [1:0] MOTOR_RIGHT = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DUTY_CAP     = 3'd0,
		CFG_MIN_DUTY     = 3'd1,
		CFG_RAMP_STEP    = 3'd2,
		CFG_HOLD_TICKS   = 3'd3,
		CFG_INVERT_LEFT  = 3'd4,
		CFG_INVERT_RIGHT = 3'd5
	} cfg_idx_t;

	// One request: motor command or update tick
	typedef struct packed {
		action_t            action;
		logic [1:0]         motor_id;
		dir_t               direction;
		logic signed [15:0] duty;
	} req_t;

	// One result: status, pin levels, compare values and applied directions
	typedef struct packed {
		status_t              status;
		logic                 left_in1;
		logic                 left_in2;
		logic [LEVEL_W-1:0]   left_compare;
		logic                 right_in1;
		logic                 right_in2;
		logic [LEVEL_W-1:0]   right_compare;
		dir_t                 left_direction;
		dir_t                 right_direction;
	} rsp_t;

endpackage

@@ hw/rtl/dual_hbridge_ramp_controller.sv @@
// Dual H-bridge controller with soft-start ramp and coast hold on reversal.
// Single module; depends on dhb_pkg for codes and payload structs.
//
// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------
// req     | req_valid / req_ready  | req_t: action, motor_id, direction, duty
// rsp     | rsp_valid / rsp_ready  | rsp_t: status, pins, compares, directions
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A request is registered in s1, then shallow logic updates the per-motor state
// and loads the result register; one request per cycle is sustained while the
// result side is ready. The input register refills in the cycle it hands its
// request on, so a stalled result register holds one result and s1 holds one
// more request. Reset puts both motors in coast with zero duty and loads the
// register defaults.
module dual_hbridge_ramp_controller
	import dhb_pkg::*;
#(
	parameter int HOLD_BITS = HOLD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (HOLD_BITS > TICKS_W) ? HOLD_BITS : TICKS_W;
	localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

	// Configuration registers
	logic [LEVEL_W-1:0] duty_cap_q, min_duty_q, ramp_step_q;
	logic [TICKS_W-1:0] hold_ticks_q;
	logic               invert_left_q, invert_right_q;

	// Per-motor state
	dir_t               applied_q [2];
	dir_t               tdir_q    [2];
	logic [LEVEL_W-1:0] cur_q     [2];
	logic [LEVEL_W-1:0] tgt_q     [2];
	logic [HOLD_BITS-1:0] hold_q  [2];
	logic               pend_q    [2];

	dir_t               applied_d [2];
	dir_t               tdir_d    [2];
	logic [LEVEL_W-1:0] cur_d     [2];
	logic [LEVEL_W-1:0] tgt_d     [2];
	logic [HOLD_BITS-1:0] hold_d  [2];
	logic               pend_d    [2];

	// Input stage and result register
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;
	rsp_t rsp_d;
	logic advance;

	// Target duty clamp with deadband floor
	function automatic logic [LEVEL_W-1:0] clamp_level(logic signed [15:0] raw,
			logic [LEVEL_W-1:0] cap_d, logic [LEVEL_W-1:0] min_d);
		logic [15:0] v;
		logic [15:0] top;
		logic [15:0] flr;
		top = ({6'b0, cap_d} < PWM_PERIOD) ? {6'b0, cap_d} : PWM_PERIOD;
		flr = ({6'b0, min_d} < PWM_PERIOD) ? {6'b0, min_d} : PWM_PERIOD;
		v = raw[15] ? 16'd0 : 16'(raw);
		if (v > top) begin
			v = top;
		end
		if (v != 16'd0 && v < flr) begin
			v = flr;
		end
		return v[LEVEL_W-1:0];
	endfunction

	// Bridge pin levels {in1, in2} after optional forward/reverse swap
	function automatic logic [1:0] pin_levels(dir_t d, logic inv);
		logic [1:0] p;
		unique case (d)
			DIR_COAST: p = 2'b00;
			DIR_FWD:   p = inv ? 2'b01 : 2'b10;
			DIR_REV:   p = inv ? 2'b10 : 2'b01;
			DIR_BRAKE: p = 2'b11;
			default:   p = 2'b00;
		endcase
		return p;
	endfunction

	// Compare value is gated off unless driving
	function automatic logic [LEVEL_W-1:0] compare_of(dir_t d, logic [LEVEL_W-1:0] lvl);
		return (d == DIR_FWD || d == DIR_REV) ? lvl : '0;
	endfunction

	// Handshakes
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_cap_q     <= 10'd1000;
			min_duty_q     <= 10'd0;
			ramp_step_q    <= 10'd20;
			hold_ticks_q   <= 8'd10;
			invert_left_q  <= 1'b0;
			invert_right_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DUTY_CAP:     duty_cap_q     <= cfg_data;
				CFG_MIN_DUTY:     min_duty_q     <= cfg_data;
				CFG_RAMP_STEP:    ramp_step_q    <= cfg_data;
				CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_data[TICKS_W-1:0];
				CFG_INVERT_LEFT:  invert_left_q  <= cfg_data[0];
				CFG_INVERT_RIGHT: invert_right_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Next state for both motors
	always_comb begin
		logic [LEVEL_W-1:0]   step;
		logic [LEVEL_W:0]     sum;
		logic [LEVEL_W-1:0]   gap;
		logic [HOLD_BITS-1:0] hc;
		logic                 ramp_ok;
		step = (ramp_step_q == '0) ? LEVEL_W'(1) : ramp_step_q;
		sum = '0;
		gap = '0;
		hc = '0;
		ramp_ok = 1'b0;
		for (int k = 0; k < 2; k++) begin
			applied_d[k] = applied_q[k];
			tdir_d[k]    = tdir_q[k];
			cur_d[k]     = cur_q[k];
			tgt_d[k]     = tgt_q[k];
			hold_d[k]    = hold_q[k];
			pend_d[k]    = pend_q[k];
			if (req_s1.action == ACT_TICK) begin
				// Hold count, then ramp toward target
				ramp_ok = 1'b1;
				if (pend_q[k]) begin
					hc = (hold_q[k] < HOLD_MAX) ? hold_q[k] + 1'b1 : hold_q[k];
					hold_d[k] = hc;
					if (CMP_W'(hc) < CMP_W'(hold_ticks_q)) begin
						ramp_ok = 1'b0;
					end else begin
						applied_d[k] = tdir_q[k];
						pend_d[k] = 1'b0;
					end
				end
				if (ramp_ok) begin
					sum = {1'b0, cur_q[k]} + {1'b0, step};
					gap = tgt_q[k] - cur_q[k];
					if (cur_q[k] < tgt_q[k]) begin
						cur_d[k] = (sum > {1'b0, tgt_q[k]}) ? tgt_q[k] : sum[LEVEL_W-1:0];
					end else if (cur_q[k] > tgt_q[k]) begin
						gap = cur_q[k] - tgt_q[k];
						cur_d[k] = (step >= gap) ? tgt_q[k] : cur_q[k] - step;
					end
				end
			end else if (req_s1.motor_id == 2'(k)) begin
				if (req_s1.direction == DIR_COAST || req_s1.direction == DIR_BRAKE) begin
					// Stop at once
					tgt_d[k]     = '0;
					cur_d[k]     = '0;
					tdir_d[k]    = req_s1.direction;
					pend_d[k]    = 1'b0;
					applied_d[k] = req_s1.direction;
				end else if (applied_q[k] == req_s1.direction) begin
					// Same direction: new target only
					tdir_d[k] = req_s1.direction;
					pend_d[k] = 1'b0;
					tgt_d[k]  = clamp_level(req_s1.duty, duty_cap_q, min_duty_q);
				end else begin
					// Reversal: coast and start hold
					tdir_d[k]    = req_s1.direction;
					pend_d[k]    = 1'b1;
					hold_d[k]    = '0;
					tgt_d[k]     = clamp_level(req_s1.duty, duty_cap_q, min_duty_q);
					cur_d[k]     = '0;
					applied_d[k] = DIR_COAST;
				end
			end
		end
	end

	// Result from the updated state
	always_comb begin
		logic [1:0] lp;
		logic [1:0] rp;
		lp = pin_levels(applied_d[0], invert_left_q);
		rp = pin_levels(applied_d[1], invert_right_q);
		rsp_d.status = (req_s1.action == ACT_CMD && req_s1.motor_id != MOTOR_LEFT
			&& req_s1.motor_id != MOTOR_RIGHT) ? ST_BAD_ID : ST_OK;
		rsp_d.left_in1        = lp[1];
		rsp_d.left_in2        = lp[0];
		rsp_d.left_compare    = compare_of(applied_d[0], cur_d[0]);
		rsp_d.right_in1       = rp[1];
		rsp_d.right_in2       = rp[0];
		rsp_d.right_compare   = compare_of(applied_d[1], cur_d[1]);
		rsp_d.left_direction  = applied_d[0];
		rsp_d.right_direction = applied_d[1];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				applied_q[k] <= DIR_COAST;
				tdir_q[k]    <= DIR_COAST;
				cur_q[k]     <= '0;
				tgt_q[k]     <= '0;
				hold_q[k]    <= '0;
				pend_q[k]    <= 1'b0;
			end
		end else if (advance) begin
			for (int k = 0; k < 2; k++) begin
				applied_q[k] <= applied_d[k];
				tdir_q[k]    <= tdir_d[k];
				cur_q[k]     <= cur_d[k];
				tgt_q[k]     <= tgt_d[k];
				hold_q[k]    <= hold_d[k];
				pend_q[k]    <= pend_d[k];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for dual_hbridge_ramp_controller: directed and random commands and ticks checked
// against an in-bench model of both bridges. Depends on dhb_pkg and the controller RTL only.
module tb;
	import dhb_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_MAX = (1 << HOLD_BITS_DEF) - 1;

	// Bridge model plus queue of predicted results
	class bridge_scoreboard;
		int unsigned duty_cap, min_duty, ramp_step, hold_ticks;
		bit inv[2];
		dir_t applied[2];
		dir_t aim_dir[2];
		int unsigned level[2];
		int unsigned aim_level[2];
		int unsigned held[2];
		bit reversing[2];
		rsp_t pending_outputs[$];
		int errors, results, requests, ticks, bad_ids;

		function void reset_state();
			duty_cap = 1000;
			min_duty = 0;
			ramp_step = 20;
			hold_ticks = 10;
			for (int k = 0; k < 2; k++) begin
				inv[k] = 1'b0;
				applied[k] = DIR_COAST;
				aim_dir[k] = DIR_COAST;
				level[k] = 0;
				aim_level[k] = 0;
				held[k] = 0;
				reversing[k] = 1'b0;
			end
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_DUTY_CAP: duty_cap = v;
				CFG_MIN_DUTY: min_duty = v;
				CFG_RAMP_STEP: ramp_step = v;
				CFG_HOLD_TICKS: hold_ticks = v[TICKS_W-1:0];
				CFG_INVERT_LEFT: inv[0] = v[0];
				CFG_INVERT_RIGHT: inv[1] = v[0];
				default: ;
			endcase
		endfunction

		// Negative to zero, cap at min(duty_cap, period), deadband floor for nonzero
		function int unsigned clamp_duty(logic signed [15:0] d);
			int unsigned v, top, flr;
			v = d[15] ? 0 : {17'b0, d[14:0]};
			top = (duty_cap < PWM_PERIOD) ? duty_cap : PWM_PERIOD;
			flr = (min_duty < PWM_PERIOD) ? min_duty : PWM_PERIOD;
			if (v > top)
				v = top;
			if (v > 0 && v < flr)
				v = flr;
			return v;
		endfunction

		function void command(int k, dir_t d, logic signed [15:0] duty);
			if (d == DIR_COAST || d == DIR_BRAKE) begin
				aim_level[k] = 0;
				level[k] = 0;
				aim_dir[k] = d;
				reversing[k] = 1'b0;
				applied[k] = d;
			end else if (applied[k] == d) begin
				aim_dir[k] = d;
				reversing[k] = 1'b0;
				aim_level[k] = clamp_duty(duty);
			end else begin
				// reversal: coast and start the hold
				aim_dir[k] = d;
				reversing[k] = 1'b1;
				held[k] = 0;
				aim_level[k] = clamp_duty(duty);
				level[k] = 0;
				applied[k] = DIR_COAST;
			end
		endfunction

		function void tick_motor(int k);
			int unsigned step;
			if (reversing[k]) begin
				if (held[k] < HOLD_MAX)
					held[k]++;
				if (held[k] < hold_ticks)
					return;
				applied[k] = aim_dir[k];
				reversing[k] = 1'b0;
			end
			step = (ramp_step == 0) ? 1 : ramp_step;
			if (level[k] < aim_level[k]) begin
				level[k] = (level[k] + step > aim_level[k]) ? aim_level[k] : level[k] + step;
			end else if (level[k] > aim_level[k]) begin
				level[k] = (step >= level[k] - aim_level[k]) ? aim_level[k] : level[k] - step;
			end
		endfunction

		function void drive_pins(dir_t d, bit invert, output logic a, output logic b);
			dir_t e;
			e = d;
			if (invert && d == DIR_FWD)
				e = DIR_REV;
			else if (invert && d == DIR_REV)
				e = DIR_FWD;
			a = (e == DIR_FWD || e == DIR_BRAKE);
			b = (e == DIR_REV || e == DIR_BRAKE);
		endfunction

		function logic [LEVEL_W-1:0] compare_of(int k);
			if (applied[k] != DIR_FWD && applied[k] != DIR_REV)
				return '0;
			return level[k][LEVEL_W-1:0];
		endfunction

		// Advance the model by one accepted request and queue its result
		function void note_request(req_t r);
			rsp_t e;
			logic a, b;
			bit bad;
			bad = 1'b0;
			requests++;
			if (r.action == ACT_TICK) begin
				tick_motor(0);
				tick_motor(1);
				ticks++;
			end else if (r.motor_id != MOTOR_LEFT && r.motor_id != MOTOR_RIGHT) begin
				bad = 1'b1;
				bad_ids++;
			end else begin
				command((r.motor_id == MOTOR_RIGHT) ? 1 : 0, r.direction, r.duty);
			end
			e = '0;
			e.status = bad ? ST_BAD_ID : ST_OK;
			drive_pins(applied[0], inv[0], a, b);
			e.left_in1 = a;
			e.left_in2 = b;
			e.left_compare = compare_of(0);
			drive_pins(applied[1], inv[1], a, b);
			e.right_in1 = a;
			e.right_in2 = b;
			e.right_compare = compare_of(1);
			e.left_direction = applied[0];
			e.right_direction = applied[1];
			pending_outputs.push_back(e);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending_outputs.size() == 0) begin
				$display("%0t: result with no request waiting, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			e = pending_outputs.pop_front();
			results++;
			compare_field("status", e.status, got.status);
			compare_field("left_in1", e.left_in1, got.left_in1);
			compare_field("left_in2", e.left_in2, got.left_in2);
			compare_field("left_compare", e.left_compare, got.left_compare);
			compare_field("right_in1", e.right_in1, got.right_in1);
			compare_field("right_in2", e.right_in2, got.right_in2);
			compare_field("right_compare", e.right_compare, got.right_compare);
			compare_field("left_direction", e.left_direction, got.left_direction);
			compare_field("right_direction", e.right_direction, got.right_direction);
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		function void finish_check();
			if (pending_outputs.size() != 0) begin
				$display("%0t: %0d results missing, expected %h, actual none",
					$time, pending_outputs.size(), pending_outputs[0]);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bridge_scoreboard book;
	bit calm = 1'b0;
	int settings_loaded = 0;
	int stall_cycles = 0;

	dual_hbridge_ramp_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result checking
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			book.check_result(rsp);
	end

	// Watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d idle cycles", stall_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side back-pressure
	initial begin
		int n;
		forever begin
			if (calm) begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				n = $urandom_range(1, 8);
				repeat (n) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic push_request(req_t r);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		book.note_request(r);
	endtask

	task automatic sender_gap();
		int n;
		if (!calm && $urandom_range(0, 9) < 2) begin
			n = $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		book.write_reg(idx, v);
	endtask

	// Drain all results, then rewrite every register
	task automatic load_settings(int mx, int mn, int rs, int hd, bit il, bit ir);
		req_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		set_register(CFG_DUTY_CAP, CFG_DATA_W'(mx));
		set_register(CFG_MIN_DUTY, CFG_DATA_W'(mn));
		set_register(CFG_RAMP_STEP, CFG_DATA_W'(rs));
		set_register(CFG_HOLD_TICKS, CFG_DATA_W'(hd));
		set_register(CFG_INVERT_LEFT, CFG_DATA_W'(il));
		set_register(CFG_INVERT_RIGHT, CFG_DATA_W'(ir));
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	function automatic req_t make_command(logic [1:0] m, dir_t d, logic signed [15:0] duty);
		req_t r;
		r.action = ACT_CMD;
		r.motor_id = m;
		r.direction = d;
		r.duty = duty;
		return r;
	endfunction

	// Tick with junk in the ignored fields
	function automatic req_t make_tick();
		req_t r;
		r.action = ACT_TICK;
		r.motor_id = 2'($urandom_range(0, 3));
		r.direction = dir_t'($urandom_range(0, 3));
		r.duty = 16'($urandom);
		return r;
	endfunction

	function automatic req_t random_request(int tick_pct, int right_pct);
		req_t r;
		if ($urandom_range(0, 99) < tick_pct)
			return make_tick();
		r = make_tick();
		r.action = ACT_CMD;
		if ($urandom_range(0, 99) < 6)
			r.motor_id = 2'($urandom_range(2, 3));
		else
			r.motor_id = ($urandom_range(0, 99) < right_pct) ? MOTOR_RIGHT : MOTOR_LEFT;
		if ($urandom_range(0, 9) < 7)
			r.direction = $urandom_range(0, 1) ? DIR_FWD : DIR_REV;
		else
			r.direction = $urandom_range(0, 1) ? DIR_COAST : DIR_BRAKE;
		case ($urandom_range(0, 9))
			0: r.duty = 16'($urandom);
			1: r.duty = 16'h8000 | 16'($urandom);
			2: r.duty = '0;
			3, 4, 5: r.duty = 16'($urandom_range(1, 60));
			default: r.duty = 16'($urandom_range(0, 1100));
		endcase
		return r;
	endfunction

	initial begin
		int items, tick_pct, right_pct;
		book = new;
		book.reset_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short hold, big ramp, deadband floor of 50
		load_settings(1000, 50, 100, 2, 1'b0, 1'b0);
		push_request(make_command(2'd2, DIR_FWD, 16'sd100));
		push_request(make_command(2'd3, DIR_BRAKE, 16'sh8000));
		push_request(make_tick());
		push_request(make_command(MOTOR_LEFT, DIR_FWD, 16'sh7fff));
		push_request(make_tick());
		push_request(make_tick());
		push_request(make_tick());
		push_request(make_command(MOTOR_LEFT, DIR_FWD, 16'sd10));
		push_request(make_tick());
		push_request(make_command(MOTOR_LEFT, DIR_FWD, 16'sh8000));
		push_request(make_tick());
		push_request(make_command(MOTOR_LEFT, DIR_FWD, 16'sd0));
		push_request(make_command(MOTOR_RIGHT, DIR_REV, 16'sd1));
		push_request(make_tick());
		push_request(make_tick());
		push_request(make_tick());
		push_request(make_command(MOTOR_RIGHT, DIR_FWD, 16'sd700));
		push_request(make_command(MOTOR_RIGHT, DIR_BRAKE, 16'sd123));
		push_request(make_command(MOTOR_LEFT, DIR_COAST, 16'sd900));
		push_request(make_command(MOTOR_LEFT, DIR_REV, 16'sd300));
		push_request(make_tick());
		push_request(make_command(MOTOR_LEFT, DIR_FWD, 16'sd300));
		push_request(make_tick());
		push_request(make_tick());
		push_request(make_tick());

		// Random phases, each with its own register setting
		for (int p = 0; p < 6; p++) begin
			items = 300;
			tick_pct = 50;
			right_pct = 50;
			case (p)
				0: load_settings(1000, 0, 20, 10, 1'b0, 1'b0);
				1: begin
					load_settings(0, 0, 0, 0, 1'b1, 1'b0);
					items = 250;
					tick_pct = 40;
				end
				2: begin
					// long hold: mostly ticks, right motor seldom commanded so reversals can finish
					load_settings(1023, 1023, 1023, 255, 1'b1, 1'b1);
					items = 400;
					tick_pct = 90;
					right_pct = 10;
				end
				3: load_settings(600, 150, 7, 3, 1'b0, 1'b1);
				4: load_settings($urandom_range(0, 1023), $urandom_range(0, 200),
					$urandom_range(0, 300), $urandom_range(0, 12),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: begin
					load_settings(1000, 999, 1, 1, 1'b0, 1'b0);
					items = 250;
					calm = 1'b1;
				end
			endcase
			for (int i = 0; i < items; i++) begin
				sender_gap();
				push_request(random_request(tick_pct, right_pct));
			end
		end

		req_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		book.finish_check();
		$display("Checked %0d results from %0d requests (%0d ticks, %0d bad motor ids)",
			book.results, book.requests, book.ticks, book.bad_ids);
		$display("across %0d register settings with %0d mismatches",
			settings_loaded, book.errors);
		if (book.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
